FILE: hw/rtl/ddo_pkg.sv
// Shared types and constants for the differential-drive odometry block.
// Holds command codes, datapath micro-ops, controller states and arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps

package ddo_pkg;

    // Request command codes
    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_SET    = 2'd1,
        CMD_ADD    = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Register map: register index is paddr[2]
    localparam int  ADDR_W           = 3;
    localparam logic REG_TRACK_WIDTH = 1'b0;
    localparam logic REG_ROLL_RADIUS = 1'b1;
    localparam logic [19:0] BASE_RESET   = 20'd10486;
    localparam logic [15:0] RADIUS_RESET = 16'd2162;

    // Arithmetic constants
    localparam logic signed [26:0] PI_Q24  = 27'sd52707179;
    localparam logic [16:0]        SIN_A   = 17'd51472;
    localparam logic [16:0]        SIN_B   = 17'd21024;
    localparam logic [16:0]        SIN_C   = 17'd2320;
    localparam logic [15:0]        QUARTER = 16'd16384;
    localparam logic signed [16:0] ONE_Q14 = 17'sd16384;

    // Restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = 36;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Datapath micro-operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_SL,
        OP_MUL_SR,
        OP_MUL_NUM,
        OP_DIV_STEP,
        OP_MUL_SUM,
        OP_MUL_PL,
        OP_MUL_PH,
        OP_TRIG_Z2,
        OP_TRIG_C,
        OP_TRIG_B,
        OP_TRIG_A,
        OP_TRIG_MUL,
        OP_APPLY
    } t_op;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SL,
        S_SR,
        S_NUM,
        S_DIV,
        S_SUM,
        S_PL,
        S_PH,
        S_Z2,
        S_YC,
        S_YB,
        S_YA,
        S_TMUL,
        S_APPLY
    } t_state;

    // Controller to datapath
    typedef struct packed {
        t_op  op;
        logic trig_sel;   // 0: cosine pass, 1: sine pass
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic upd_req;    // offered request is an encoder update
        logic out_free;   // output register can take a result this cycle
    } t_dp_stat;

    // Signed 32-bit add with saturation
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -33'sd2147483648) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

endpackage

FILE: hw/rtl/ddo_if.sv
// Request and result channel interfaces of the odometry block.
// Valid/ready handshake; widths follow the field definitions.
`timescale 1ns / 1ps

interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [15:0]        left_wheel_angle;
    logic [15:0]        right_wheel_angle;
    logic signed [15:0] left_slip;
    logic signed [15:0] right_slip;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic [15:0]        new_theta;

    modport source (output valid, command, left_wheel_angle, right_wheel_angle,
                    left_slip, right_slip, new_x, new_y, new_theta, input ready);
    modport sink (input valid, command, left_wheel_angle, right_wheel_angle,
                  left_slip, right_slip, new_x, new_y, new_theta, output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic [15:0]        theta_out;
    logic [15:0]        left_wheel_out;
    logic [15:0]        right_wheel_out;

    modport source (output valid, x_out, y_out, theta_out, left_wheel_out,
                    right_wheel_out, input ready);
    modport sink (input valid, x_out, y_out, theta_out, left_wheel_out,
                  right_wheel_out, output ready);
endinterface

FILE: hw/rtl/ddo_ctrl.sv
// Sequencer of the odometry block: issues one datapath micro-op per cycle, holding while the output register is full.
// Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ddo_pkg::t_dp_stat i_stat,
    output ddo_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_ready
);
    import ddo_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pass, n_pass;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
        end
    end

    // Next state and micro-op
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_pass         = r_pass;
        o_cmd.op       = OP_NONE;
        o_cmd.trig_sel = r_pass;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_pass     = 1'b0;
                n_cnt      = '0;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = i_stat.upd_req ? S_SL : S_APPLY;
                end
            end
            S_SL: begin
                o_cmd.op = OP_MUL_SL;
                n_state  = S_SR;
            end
            S_SR: begin
                o_cmd.op = OP_MUL_SR;
                n_state  = S_NUM;
            end
            S_NUM: begin
                o_cmd.op = OP_MUL_NUM;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.op = OP_MUL_SUM;
                n_state  = S_PL;
            end
            S_PL: begin
                o_cmd.op = OP_MUL_PL;
                n_state  = S_PH;
            end
            S_PH: begin
                o_cmd.op = OP_MUL_PH;
                n_state  = S_Z2;
            end
            S_Z2: begin
                o_cmd.op = OP_TRIG_Z2;
                n_state  = S_YC;
            end
            S_YC: begin
                o_cmd.op = OP_TRIG_C;
                n_state  = S_YB;
            end
            S_YB: begin
                o_cmd.op = OP_TRIG_B;
                n_state  = S_YA;
            end
            S_YA: begin
                o_cmd.op = OP_TRIG_A;
                n_state  = S_TMUL;
            end
            // cosine pass first, then sine pass
            S_TMUL: begin
                o_cmd.op = OP_TRIG_MUL;
                if (r_pass) begin
                    n_state = S_APPLY;
                end else begin
                    n_pass  = 1'b1;
                    n_state = S_Z2;
                end
            end
            // wait for the output register
            S_APPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_APPLY;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ddo_dp.sv
// Datapath of the odometry block: pose state, shared multiplier, divider, sine unit.
// Depends on ddo_pkg and ddo_if.
`timescale 1ns / 1ps

module ddo_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [19:0]       i_track_width,
    input  logic [15:0]       i_roll_radius,
    input  ddo_pkg::t_dp_cmd  i_cmd,
    output ddo_pkg::t_dp_stat o_stat,
    ddo_in_if.sink            i_in,
    ddo_out_if.source         o_out
);
    import ddo_pkg::*;

    // Latched request
    t_cmd               r_cmd;
    logic [15:0]        r_la, r_ra, r_nth;
    logic signed [15:0] r_ls, r_rs;
    logic signed [31:0] r_nx, r_ny;

    // Pose state
    logic signed [31:0] r_x, r_y;
    logic [15:0]        r_hd, r_lst, r_rst;

    // Intermediate results
    logic signed [18:0] r_sl, r_sr;
    logic               r_neg;
    logic [35:0]        r_quo;
    logic [19:0]        r_rem;
    logic signed [35:0] r_sum;
    logic signed [45:0] r_pl;
    logic signed [23:0] r_dist;
    logic [16:0]        r_z2, r_ty;
    logic signed [17:0] r_trig;
    logic signed [23:0] r_dx, r_dy;

    // Result register
    logic r_oval;

    // Wrapped wheel changes and slip factors
    logic signed [15:0] w_dl, w_dr;
    logic signed [16:0] w_oml, w_omr;
    logic signed [19:0] w_sdiff, w_ssum;
    assign w_dl    = $signed(r_la - r_lst);
    assign w_dr    = $signed(r_ra - r_rst);
    assign w_oml   = ONE_Q14 - 17'(r_ls);
    assign w_omr   = ONE_Q14 - 17'(r_rs);
    assign w_sdiff = 20'(r_sr) - 20'(r_sl);
    assign w_ssum  = 20'(r_sr) + 20'(r_sl);

    // Quadrant fold for the current trig pass
    logic [15:0] w_ang, w_z;
    logic [1:0]  w_q;
    logic [14:0] w_tt;
    assign w_ang = i_cmd.trig_sel ? r_hd : r_hd + QUARTER;
    assign w_q   = w_ang[15:14];
    assign w_tt  = w_q[0] ? 15'(QUARTER - {2'b00, w_ang[13:0]}) : {1'b0, w_ang[13:0]};
    assign w_z   = {w_tt, 1'b0};

    // Shared multiplier operand select
    logic signed [23:0] w_ma;
    logic signed [26:0] w_mb;
    logic signed [50:0] w_prod;
    logic [16:0]        w_p15;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_MUL_SL: begin
                w_ma = 24'(w_dl);
                w_mb = 27'(w_oml);
            end
            OP_MUL_SR: begin
                w_ma = 24'(w_dr);
                w_mb = 27'(w_omr);
            end
            OP_MUL_NUM: begin
                w_ma = 24'(w_sdiff);
                w_mb = $signed({11'd0, i_roll_radius});
            end
            OP_MUL_SUM: begin
                w_ma = 24'(w_ssum);
                w_mb = $signed({11'd0, i_roll_radius});
            end
            OP_MUL_PL: begin
                w_ma = $signed({6'd0, r_sum[17:0]});
                w_mb = PI_Q24;
            end
            OP_MUL_PH: begin
                w_ma = 24'($signed(r_sum[35:18]));
                w_mb = PI_Q24;
            end
            OP_TRIG_Z2: begin
                w_ma = $signed({8'd0, w_z});
                w_mb = $signed({11'd0, w_z});
            end
            OP_TRIG_C: begin
                w_ma = $signed({7'd0, r_z2});
                w_mb = $signed({10'd0, SIN_C});
            end
            OP_TRIG_B: begin
                w_ma = $signed({7'd0, r_ty});
                w_mb = $signed({10'd0, r_z2});
            end
            OP_TRIG_A: begin
                w_ma = $signed({7'd0, r_ty});
                w_mb = $signed({11'd0, w_z});
            end
            OP_TRIG_MUL: begin
                w_ma = r_dist;
                w_mb = 27'(r_trig);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = 51'(w_ma) * 51'(w_mb);
    assign w_p15  = w_prod[31:15];

    // Forward step: high partial product recombined with the low one
    logic signed [63:0] w_full;
    assign w_full = (64'(w_prod) <<< 18) + 64'(r_pl);

    // Divider step
    logic [19:0] w_base;
    logic [20:0] w_rsh;
    logic        w_ge;
    assign w_base = (i_track_width == '0) ? 20'd1 : i_track_width;
    assign w_rsh  = {r_rem, r_quo[35]};
    assign w_ge   = w_rsh >= {1'b0, w_base};

    // Heading change, truncated toward zero, modulo one turn
    logic [15:0] w_dth;
    assign w_dth = r_neg ? 16'(-r_quo[15:0]) : r_quo[15:0];

    // Arithmetic registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cmd <= t_cmd'(i_in.command);
                r_la  <= i_in.left_wheel_angle;
                r_ra  <= i_in.right_wheel_angle;
                r_ls  <= i_in.left_slip;
                r_rs  <= i_in.right_slip;
                r_nx  <= i_in.new_x;
                r_ny  <= i_in.new_y;
                r_nth <= i_in.new_theta;
            end
            OP_MUL_SL: r_sl <= 19'(w_prod >>> 14);
            OP_MUL_SR: r_sr <= 19'(w_prod >>> 14);
            OP_MUL_NUM: begin
                r_neg <= w_prod[35];
                r_quo <= w_prod[35] ? 36'(-w_prod[35:0]) : w_prod[35:0];
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= w_ge ? 20'(w_rsh - {1'b0, w_base}) : w_rsh[19:0];
                r_quo <= {r_quo[34:0], w_ge};
            end
            OP_MUL_SUM: r_sum <= w_prod[35:0];
            OP_MUL_PL:  r_pl  <= w_prod[45:0];
            OP_MUL_PH:  r_dist <= 24'(w_full >>> 40);
            OP_TRIG_Z2: r_z2 <= w_p15;
            OP_TRIG_C:  r_ty <= SIN_B - w_p15;
            OP_TRIG_B:  r_ty <= SIN_A - w_p15;
            OP_TRIG_A:  r_trig <= w_q[1] ? -$signed({1'b0, w_p15}) : $signed({1'b0, w_p15});
            OP_TRIG_MUL: begin
                if (i_cmd.trig_sel) begin
                    r_dy <= 24'(w_prod >>> 15);
                end else begin
                    r_dx <= 24'(w_prod >>> 15);
                end
            end
            default: begin
            end
        endcase
    end

    // Pose state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_y    <= '0;
            r_hd   <= '0;
            r_lst  <= '0;
            r_rst  <= '0;
            r_oval <= 1'b0;
        end else if (i_cmd.op == OP_APPLY) begin
            r_oval <= 1'b1;
            case (r_cmd)
                CMD_UPDATE: begin
                    r_x   <= sat_add(r_x, 32'(r_dx));
                    r_y   <= sat_add(r_y, 32'(r_dy));
                    r_hd  <= r_hd + w_dth;
                    r_lst <= r_la;
                    r_rst <= r_ra;
                end
                CMD_SET: begin
                    r_x  <= r_nx;
                    r_y  <= r_ny;
                    r_hd <= r_nth;
                end
                CMD_ADD: begin
                    r_x  <= sat_add(r_x, r_nx);
                    r_y  <= sat_add(r_y, r_ny);
                    r_hd <= r_hd + r_nth;
                end
                default: begin
                end
            endcase
        end else if (o_out.ready) begin
            r_oval <= 1'b0;
        end
    end

    // The result shows the pose after the request
    assign o_out.valid           = r_oval;
    assign o_out.x_out           = r_x;
    assign o_out.y_out           = r_y;
    assign o_out.theta_out       = r_hd;
    assign o_out.left_wheel_out  = r_lst;
    assign o_out.right_wheel_out = r_rst;

    assign o_stat.upd_req  = (i_in.command == CMD_UPDATE);
    assign o_stat.out_free = !r_oval || o_out.ready;

endmodule

FILE: hw/rtl/diff_drive_odometry.sv
// Top level of the differential-drive odometry block: APB registers, sequencer, datapath.
// Depends on ddo_pkg, ddo_if, ddo_ctrl and ddo_dp.
//
//   channel   dir   handshake      payload
//   i_in      in    valid/ready    command, wheel angles, slips, new pose
//   o_out     out   valid/ready    pose and stored wheel angles
//   apb       in    psel/penable   track width @0x0, roll radius @0x4
//
// An encoder update runs 3 multiplies, a restoring divider with a 36-bit quotient
// for the heading change, 3 multiplies for the forward step, and a cosine pass
// then a sine pass on the shared multiplier.
// Set, add and unused commands go straight to write-back. One request is in work at a time.
// Reset is synchronous active low and clears the pose; the result register
// holds a result until taken, stalling only the final write-back.
`timescale 1ns / 1ps

module diff_drive_odometry (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    ddo_in_if.sink                    i_in,
    ddo_out_if.source                 o_out,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import ddo_pkg::*;

    logic [19:0] r_track_width;
    logic [15:0] r_roll_radius;
    logic        w_wr;
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    logic        w_in_ready;

    // Configuration registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_width <= BASE_RESET;
            r_roll_radius <= RADIUS_RESET;
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_TRACK_WIDTH) begin
                r_track_width <= pwdata[19:0];
            end else begin
                r_roll_radius <= pwdata[15:0];
            end
        end
    end

    // Read-back
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_ROLL_RADIUS) begin
                prdata = {16'd0, r_roll_radius};
            end else begin
                prdata = {12'd0, r_track_width};
            end
        end
    end

    // No request is taken while reset is held
    assign i_in.ready = w_in_ready && i_rst_n;

    // Sequencer
    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    // Datapath
    ddo_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_track_width (r_track_width),
        .i_roll_radius (r_roll_radius),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in          (i_in),
        .o_out         (o_out)
    );

endmodule

FILE: test/tb_diff_drive_odometry.sv
// Testbench for the differential-drive odometry block: random and directed requests,
// a scoreboard class predicting pose and wheel stores, APB register writes between phases.
// Depends on ddo_pkg, ddo_if and diff_drive_odometry.
`timescale 1ns / 1ps

module tb_diff_drive_odometry;
    import ddo_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        th;
        logic [15:0]        lw;
        logic [15:0]        rw;
    } t_pose;

    // Pose predictor plus queue of expected poses
    class t_pose_board;
        logic [19:0]        base;
        logic [15:0]        radius;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        hd;
        logic [15:0]        lst;
        logic [15:0]        rst;
        t_pose              pending[$];
        int                 errors;

        function new();
            base = BASE_RESET; radius = RADIUS_RESET;
            px = 0; py = 0; hd = 0; lst = 0; rst = 0; errors = 0;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint qsin(longint t);
            longint z, z2, v;
            z = t * 2;
            z2 = (z * z) >>> 15;
            v = (2320 * z2) >>> 15;
            v = ((21024 - v) * z2) >>> 15;
            v = ((51472 - v) * z) >>> 15;
            return v;
        endfunction

        function longint sine(logic [15:0] a);
            longint v;
            v = a[14] ? qsin(16384 - a[13:0]) : qsin(a[13:0]);
            return a[15] ? -v : v;
        endfunction

        function void note_request(t_cmd cmd, logic [15:0] la, logic [15:0] ra,
                                   logic signed [15:0] ls, logic signed [15:0] rs,
                                   logic signed [31:0] nx, logic signed [31:0] ny,
                                   logic [15:0] nth);
            logic [15:0] dlw, drw;
            longint dl, dr, sl, sr, b, dth, fwd, c, s;
            t_pose p;
            if (cmd == CMD_UPDATE) begin
                dlw = la - lst; drw = ra - rst;
                dl = longint'($signed(dlw)); dr = longint'($signed(drw));
                sl = (dl * (16384 - longint'(ls))) >>> 14;
                sr = (dr * (16384 - longint'(rs))) >>> 14;
                b = (base == 0) ? 1 : longint'(base);
                dth = ((sr - sl) * longint'(radius)) / b;
                fwd = ((sr + sl) * longint'(radius) * 52707179) >>> 40;
                c = sine(hd + 16'd16384);
                s = sine(hd);
                lst = la; rst = ra;
                hd = hd + dth[15:0];
                px = 32'(sat(longint'(px) + ((fwd * c) >>> 15)));
                py = 32'(sat(longint'(py) + ((fwd * s) >>> 15)));
            end else if (cmd == CMD_SET) begin
                px = nx; py = ny; hd = nth;
            end else if (cmd == CMD_ADD) begin
                px = 32'(sat(longint'(px) + longint'(nx)));
                py = 32'(sat(longint'(py) + longint'(ny)));
                hd = hd + nth;
            end
            p.x = px; p.y = py; p.th = hd; p.lw = lst; p.rw = rst;
            pending.push_back(p);
        endfunction

        function void check_result(t_pose got);
            t_pose e;
            if (pending.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x) begin
                $error("x_out expected %0d got %0d", e.x, got.x); errors++;
            end
            if (got.y !== e.y) begin
                $error("y_out expected %0d got %0d", e.y, got.y); errors++;
            end
            if (got.th !== e.th) begin
                $error("theta_out expected %0d got %0d", e.th, got.th); errors++;
            end
            if (got.lw !== e.lw) begin
                $error("left_wheel_out expected %0d got %0d", e.lw, got.lw); errors++;
            end
            if (got.rw !== e.rw) begin
                $error("right_wheel_out expected %0d got %0d", e.rw, got.rw); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ddo_in_if  req_if();
    ddo_out_if res_if();

    diff_drive_odometry dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_if.sink), .o_out(res_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_pose_board board = new();
    bit quiet = 0;        // no idling in the final stretch
    bit hold_off = 0;     // long receiver stall request
    int sent = 0;

    always #2 i_clk = ~i_clk;

    initial begin
        req_if.valid = 0; req_if.command = CMD_UPDATE;
        req_if.left_wheel_angle = 0; req_if.right_wheel_angle = 0;
        req_if.left_slip = 0; req_if.right_slip = 0;
        req_if.new_x = 0; req_if.new_y = 0; req_if.new_theta = 0;
        res_if.ready = 0;
    end

    // Result side: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        t_pose g;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            g.x = res_if.x_out; g.y = res_if.y_out; g.th = res_if.theta_out;
            g.lw = res_if.left_wheel_out; g.rw = res_if.right_wheel_out;
            board.check_result(g);
        end
    end

    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                res_if.ready <= 0;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 0;
                n = $urandom_range(1, 4);
                repeat (n) @(posedge i_clk);
            end else begin
                res_if.ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic apb_write(input logic idx, input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_TRACK_WIDTH) board.base = v[19:0];
        else board.radius = v[15:0];
    endtask

    task automatic send_request(input t_cmd cmd, input logic [15:0] la, input logic [15:0] ra,
                                input logic signed [15:0] ls, input logic signed [15:0] rs,
                                input logic signed [31:0] nx, input logic signed [31:0] ny,
                                input logic [15:0] nth);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 0;
            n = $urandom_range(1, 4);
            repeat (n) @(posedge i_clk);
        end
        req_if.valid <= 1; req_if.command <= cmd;
        req_if.left_wheel_angle <= la; req_if.right_wheel_angle <= ra;
        req_if.left_slip <= ls; req_if.right_slip <= rs;
        req_if.new_x <= nx; req_if.new_y <= ny; req_if.new_theta <= nth;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_request(cmd, la, ra, ls, rs, nx, ny, nth);
        sent++;
    endtask

    task automatic drain();
        int w;
        req_if.valid <= 0;
        w = 0;
        while (board.pending.size() != 0 && w < 200000) begin
            @(posedge i_clk); w++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    // Mostly updates with small wheel steps, some set/add and unused commands
    task automatic random_request();
        int r;
        logic [15:0] la, ra;
        logic signed [15:0] ls, rs;
        r = $urandom_range(0, 99);
        la = board.lst + 16'($signed($urandom_range(0, 4000)) - 2000);
        ra = board.rst + 16'($signed($urandom_range(0, 4000)) - 2000);
        if ($urandom_range(0, 9) == 0) begin
            la = 16'($urandom); ra = 16'($urandom);
        end
        ls = 16'($signed($urandom_range(0, 32768)) - 16384);
        rs = 16'($signed($urandom_range(0, 32768)) - 16384);
        if ($urandom_range(0, 19) == 0) begin
            ls = 16'($urandom); rs = 16'($urandom);
        end
        if (r < 75)
            send_request(CMD_UPDATE, la, ra, ls, rs, $urandom, $urandom, 16'($urandom));
        else if (r < 85)
            send_request(CMD_SET, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), $urandom, $urandom, 16'($urandom));
        else if (r < 96)
            send_request(CMD_ADD, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), $urandom, $urandom, 16'($urandom));
        else
            send_request(CMD_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), $urandom, $urandom, 16'($urandom));
    endtask

    initial begin
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, special cases, every command
        send_request(CMD_UPDATE, 16'd32768, 16'd32768, 16'sd0, 16'sd0, 0, 0, 0);
        send_request(CMD_UPDATE, 16'd0, 16'd65535, 16'sh8000, 16'sh7FFF, 0, 0, 0);
        send_request(CMD_UPDATE, 16'd100, 16'd300, 16'sd16384, -16'sd16384, 0, 0, 0);
        send_request(CMD_SET, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh7FFF,
                     32'sh7FFFFF00, 32'sh80000100, 16'hFFFF);
        send_request(CMD_ADD, 0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 16'd2);
        send_request(CMD_NONE, 16'hFFFF, 16'hFFFF, 16'shFFFF, 16'shFFFF,
                     32'shFFFFFFFF, 32'shFFFFFFFF, 16'hFFFF);
        send_request(CMD_SET, 0, 0, 0, 0, 32'sh7FFFFFF0, 32'sh80000010, 16'd16384);
        send_request(CMD_UPDATE, 16'd20000, 16'd20000, 16'sd0, 16'sd0, 0, 0, 0);
        send_request(CMD_SET, 0, 0, 0, 0, 0, 0, 16'd49152);
        send_request(CMD_UPDATE, 16'd12000, 16'd28000, -16'sd8000, 16'sd4000, 0, 0, 0);
        send_request(CMD_ADD, 0, 0, 0, 0, -32'sd1000, 32'sd1000, 16'd40000);
        drain();

        // Configuration phases: extremes and zero base
        apb_write(REG_TRACK_WIDTH, 32'd0);
        apb_write(REG_ROLL_RADIUS, 32'd65535);
        for (k = 0; k < 6; k++) random_request();
        send_request(CMD_UPDATE, board.lst + 16'd32768, board.rst + 16'd32767,
                     16'sd0, -16'sd16384, 0, 0, 0);
        drain();
        apb_write(REG_TRACK_WIDTH, 32'hFFFFFFFF);
        apb_write(REG_ROLL_RADIUS, 32'd1);
        for (k = 0; k < 8; k++) random_request();
        drain();

        for (k = 0; k < 1000; k++) begin
            if (k % 250 == 0) begin
                drain();
                apb_write(REG_TRACK_WIDTH, $urandom_range(1, 1048575));
                apb_write(REG_ROLL_RADIUS, $urandom_range(1, 65535));
                if (k == 500) begin
                    apb_write(REG_TRACK_WIDTH, 32'd10486);
                    apb_write(REG_ROLL_RADIUS, 32'd2162);
                end
            end
            if (k == 300) hold_off = 1;
            if (k == 850) quiet = 1;
            random_request();
        end
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_if.sv
hw/rtl/ddo_ctrl.sv
hw/rtl/ddo_dp.sv
hw/rtl/diff_drive_odometry.sv
test/tb_diff_drive_odometry.sv
